[sv/nfbt_pkg.sv]
// Package for the next-fit boundary-tag allocator.
// Holds default sizes, field widths, the controller state and datapath command types.
// No dependencies.
package nfbt_pkg;

  // Default arena geometry, in bytes
  localparam int unsigned ARENA_BYTES_DEF   = 1048576;
  localparam int unsigned LARGEST_BLOCK_DEF = 4096;
  localparam int unsigned SPLIT_MINIMUM_DEF = 32;

  // Fixed field widths
  localparam int unsigned REQ_W  = 16;
  localparam int unsigned ADDR_W = 20;
  // Granules needed by the largest rounded request (131072 bytes / 8)
  localparam int unsigned NEED_W = 15;

  // Controller states, one-hot
  typedef enum logic [16:0] {
    S_CLEAR     = 17'h00001,
    S_IDLE      = 17'h00002,
    S_DECODE    = 17'h00004,
    S_FREE_RD   = 17'h00008,
    S_FREE_WR   = 17'h00010,
    S_F_RD      = 17'h00020,
    S_F_EVAL    = 17'h00040,
    S_B_START   = 17'h00080,
    S_B_RD      = 17'h00100,
    S_B_EVAL    = 17'h00200,
    S_C_RD      = 17'h00400,
    S_C_EVAL    = 17'h00800,
    S_CLAIM     = 17'h01000,
    S_SPLIT     = 17'h02000,
    S_DONE_OK   = 17'h04000,
    S_DONE_FAIL = 17'h08000,
    S_DONE_FREE = 17'h10000
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_FREE_RD,
    OP_FREE_WR,
    OP_HEAD_RD,
    OP_FWD_STEP,
    OP_BACK_INIT,
    OP_TAIL_RD,
    OP_BACK_STEP,
    OP_CLAIM,
    OP_SPLIT,
    OP_RES_OK,
    OP_RES_FAIL,
    OP_RES_ZERO
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;   // last entry of the tag clearing pass
    logic is_free;    // current transaction is a free
    logic free_ok;    // free address has low bits 4 and a granule inside the arena
    logic pos_in;     // walk position below arena end
    logic blk_end;    // head tag read holds size zero
    logic fit;        // block read is free, big enough and inside the arena
    logic split;      // remainder worth splitting off
    logic ss_valid;   // a block has been allocated since reset
    logic back_ok;    // backward walk position in range
    logic back_stop;  // tail tag read ends the backward walk
  } dp_stat_t;

endpackage

[sv/nfbt_ctrl.sv]
// Controller for the next-fit boundary-tag allocator.
// Sequences clearing, free and the forward/backward walks; depends on nfbt_pkg.
module nfbt_ctrl
  import nfbt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  // State register and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_DONE_OK || state == S_DONE_FAIL || state == S_DONE_FREE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_free) state_next = stat.free_ok ? S_FREE_RD : S_DONE_FREE;
        else              state_next = S_F_RD;
      end
      S_FREE_RD: begin
        cmd.op     = OP_FREE_RD;
        state_next = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.op     = OP_FREE_WR;
        state_next = S_DONE_FREE;
      end
      S_F_RD: begin
        if (stat.pos_in) begin
          cmd.op     = OP_HEAD_RD;
          state_next = S_F_EVAL;
        end else begin
          state_next = S_B_START;
        end
      end
      S_F_EVAL: begin
        if (stat.blk_end) begin
          state_next = S_B_START;
        end else if (stat.fit) begin
          state_next = S_CLAIM;
        end else begin
          cmd.op     = OP_FWD_STEP;
          state_next = S_F_RD;
        end
      end
      S_B_START: begin
        if (stat.ss_valid) begin
          cmd.op     = OP_BACK_INIT;
          state_next = S_B_RD;
        end else begin
          state_next = S_DONE_FAIL;
        end
      end
      S_B_RD: begin
        if (stat.back_ok) begin
          cmd.op     = OP_TAIL_RD;
          state_next = S_B_EVAL;
        end else begin
          state_next = S_DONE_FAIL;
        end
      end
      S_B_EVAL: begin
        if (stat.back_stop) begin
          state_next = S_DONE_FAIL;
        end else begin
          cmd.op     = OP_BACK_STEP;
          state_next = S_C_RD;
        end
      end
      S_C_RD: begin
        cmd.op     = OP_HEAD_RD;
        state_next = S_C_EVAL;
      end
      S_C_EVAL: begin
        state_next = stat.fit ? S_CLAIM : S_B_RD;
      end
      S_CLAIM: begin
        cmd.op     = OP_CLAIM;
        state_next = stat.split ? S_SPLIT : S_DONE_OK;
      end
      S_SPLIT: begin
        cmd.op     = OP_SPLIT;
        state_next = S_DONE_OK;
      end
      S_DONE_OK: begin
        if (out_free) begin
          cmd.op     = OP_RES_OK;
          state_next = S_IDLE;
        end
      end
      S_DONE_FAIL: begin
        if (out_free) begin
          cmd.op     = OP_RES_FAIL;
          state_next = S_IDLE;
        end
      end
      S_DONE_FREE: begin
        if (out_free) begin
          cmd.op     = OP_RES_ZERO;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

[sv/nfbt_datapath.sv]
// Datapath for the next-fit boundary-tag allocator: head and tail tag memories,
// walk position, request size rounding and result registers. Depends on nfbt_pkg.
module nfbt_datapath
  import nfbt_pkg::*;
#(
  parameter int unsigned ARENA_BYTES   = ARENA_BYTES_DEF,
  parameter int unsigned LARGEST_BLOCK = LARGEST_BLOCK_DEF,
  parameter int unsigned SPLIT_MINIMUM = SPLIT_MINIMUM_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              mode,
  input  logic [REQ_W-1:0]  request_size,
  input  logic [ADDR_W-1:0] free_address,
  output logic              status,
  output logic [ADDR_W-1:0] address
);

  localparam int unsigned GRAN     = ARENA_BYTES / 8;
  localparam int unsigned GW       = $clog2(GRAN);
  localparam int unsigned PW       = GW + 1;
  localparam int unsigned BG       = LARGEST_BLOCK / 8;
  localparam int unsigned SZ_W     = $clog2(BG + 1);
  localparam int unsigned TAG_W    = SZ_W + 1;
  localparam int unsigned OW       = $clog2(BG);
  localparam int unsigned SPLIT_GR = SPLIT_MINIMUM / 8;

  // Tag memories
  logic [TAG_W-1:0] head_mem [GRAN];
  logic [TAG_W-1:0] tail_mem [GRAN];
  logic [TAG_W-1:0] head_rd, tail_rd;
  logic             head_we, tail_we, head_re, tail_re;
  logic [GW-1:0]    head_wa, tail_wa, head_ra, tail_ra;
  logic [TAG_W-1:0] head_wd, tail_wd;

  // Transaction and walk registers
  logic              is_free;
  logic [GW-1:0]     fg;
  logic              fg_ok;
  logic [NEED_W-1:0] need;
  logic [PW-1:0]     pos;
  logic [GW-1:0]     ss;
  logic              ss_valid;
  logic [GW-1:0]     clr_idx;
  logic [OW-1:0]     clr_off;

  // Size rounding: smallest power of two not below request + 8
  logic [16:0] want_m1, smear;
  logic [17:0] p2;

  logic [SZ_W-1:0] hsz, tsz, rest, fin;
  logic [TAG_W-1:0] used_tag, rest_tag, blk_tag;
  logic            clr_blk_ok;

  always_comb begin
    want_m1 = {1'b0, request_size} + 17'd7;
    smear   = want_m1;
    smear   = smear | (smear >> 1);
    smear   = smear | (smear >> 2);
    smear   = smear | (smear >> 4);
    smear   = smear | (smear >> 8);
    smear   = smear | (smear >> 16);
    p2      = {1'b0, smear} + 18'd1;
  end

  // Tag decode and fit checks
  assign hsz      = head_rd[TAG_W-1:1];
  assign tsz      = tail_rd[TAG_W-1:1];
  assign rest     = hsz - SZ_W'(need);
  assign fin      = stat.split ? SZ_W'(need) : hsz;
  assign used_tag = {fin, 1'b1};
  assign rest_tag = {rest, 1'b0};
  assign blk_tag  = TAG_W'(BG << 1);
  assign clr_blk_ok = (32'(clr_idx) + 32'(BG) - 32'(clr_off)) <= 32'(GRAN);

  always_comb begin
    stat.clr_last  = clr_idx == GW'(GRAN - 1);
    stat.is_free   = is_free;
    stat.free_ok   = fg_ok;
    stat.pos_in    = 32'(pos) < 32'(GRAN);
    stat.blk_end   = hsz == '0;
    stat.fit       = !head_rd[0] && hsz != '0 && 32'(hsz) >= 32'(need)
                     && (32'(pos) + 32'(hsz)) <= 32'(GRAN);
    stat.split     = 32'(rest) > 32'(SPLIT_GR);
    stat.ss_valid  = ss_valid;
    stat.back_ok   = pos != '0 && 32'(pos) <= 32'(GRAN);
    stat.back_stop = tsz == '0 || 32'(tsz) > 32'(pos);
  end

  // Memory port control
  always_comb begin
    head_we = 1'b0;
    tail_we = 1'b0;
    head_re = 1'b0;
    tail_re = 1'b0;
    head_wa = pos[GW-1:0];
    tail_wa = GW'(pos + PW'(fin) - PW'(1));
    head_wd = used_tag;
    tail_wd = used_tag;
    head_ra = pos[GW-1:0];
    tail_ra = GW'(pos - PW'(1));
    case (cmd.op)
      OP_CLEAR: begin
        head_we = 1'b1;
        tail_we = 1'b1;
        head_wa = clr_idx;
        tail_wa = clr_idx;
        head_wd = (clr_off == '0 && clr_blk_ok) ? blk_tag : '0;
        tail_wd = (clr_off == OW'(BG - 1) && clr_blk_ok) ? blk_tag : '0;
      end
      OP_FREE_RD: begin
        head_re = 1'b1;
        head_ra = fg;
      end
      OP_FREE_WR: begin
        head_we = 1'b1;
        head_wa = fg;
        head_wd = {head_rd[TAG_W-1:1], 1'b0};
      end
      OP_HEAD_RD: head_re = 1'b1;
      OP_TAIL_RD: tail_re = 1'b1;
      OP_CLAIM: begin
        head_we = 1'b1;
        tail_we = 1'b1;
      end
      OP_SPLIT: begin
        head_we = 1'b1;
        tail_we = 1'b1;
        head_wa = GW'(pos + PW'(need));
        tail_wa = GW'(pos + PW'(hsz) - PW'(1));
        head_wd = rest_tag;
        tail_wd = rest_tag;
      end
      default: begin
      end
    endcase
  end

  // Head tag memory
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd <= head_mem[head_ra];
  end

  // Tail tag memory
  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (tail_re) tail_rd <= tail_mem[tail_ra];
  end

  // Control registers: clearing pass counters and search start
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      clr_off  <= '0;
      ss       <= '0;
      ss_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) begin
        clr_idx <= clr_idx + GW'(1);
        clr_off <= (clr_off == OW'(BG - 1)) ? '0 : clr_off + OW'(1);
      end
      if (cmd.op == OP_CLAIM) begin
        ss       <= pos[GW-1:0];
        ss_valid <= 1'b1;
      end
    end
  end

  // Transaction, walk and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        is_free <= mode;
        fg      <= GW'(free_address >> 3);
        fg_ok   <= free_address[2:0] == 3'd4 && 32'(free_address >> 3) < 32'(GRAN);
        need    <= p2[17:3];
        pos     <= ss_valid ? {1'b0, ss} : '0;
      end
      OP_FWD_STEP:  pos <= pos + PW'(hsz);
      OP_BACK_INIT: pos <= {1'b0, ss};
      OP_BACK_STEP: pos <= pos - PW'(tsz);
      OP_RES_OK: begin
        status  <= 1'b0;
        address <= ADDR_W'({pos, 3'b100});
      end
      OP_RES_FAIL: begin
        status  <= 1'b1;
        address <= '0;
      end
      OP_RES_ZERO: begin
        status  <= 1'b0;
        address <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/next_fit_boundary_tag_allocator_top.sv]
// Top level of the next-fit boundary-tag allocator; needs nfbt_pkg, nfbt_ctrl, nfbt_datapath.
// A free passes DECODE, FREE_RD, FREE_WR and DONE_FREE before its result is raised (DECODE to
// DONE_FREE directly for an ignored address); an allocate visits F_RD, F_EVAL per block walked
// forward and B_RD, B_EVAL, C_RD, C_EVAL per block walked backward, plus decode, walk end, claim,
// split and result, so it grows with fragmentation. One transaction is worked at a time; intake
// reopens in the same cycle as the result is raised. Reset: a clearing pass writes every tag,
// ARENA_BYTES/8 entries per memory (131072 by default), with in_ready low throughout.
module next_fit_boundary_tag_allocator_top
  import nfbt_pkg::*;
#(
  parameter int unsigned ARENA_BYTES   = ARENA_BYTES_DEF,
  parameter int unsigned LARGEST_BLOCK = LARGEST_BLOCK_DEF,
  parameter int unsigned SPLIT_MINIMUM = SPLIT_MINIMUM_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [REQ_W-1:0]  request_size,
  input  logic [ADDR_W-1:0] free_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic [ADDR_W-1:0] address
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nfbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nfbt_datapath #(
    .ARENA_BYTES   (ARENA_BYTES),
    .LARGEST_BLOCK (LARGEST_BLOCK),
    .SPLIT_MINIMUM (SPLIT_MINIMUM)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .request_size (request_size),
    .free_address (free_address),
    .status       (status),
    .address      (address)
  );

  // One transaction in flight: intake closes right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("intake still open after accepting a transaction");

  // A result only appears from a busy controller
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised while idle");

  // Search start, once set, is kept until reset
  a_ss_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(stat.ss_valid))
    else $error("search start lost outside reset");

endmodule
